/* hdl/plst_pkg.sv */
// Shared types and constants for the positional list store.
// Used by plst_front, plst_back and positional_list_store; no dependencies.
package plst_pkg;

   localparam int OP_W      = 3;
   localparam int VAL_W     = 32;
   localparam int POS_W     = 8;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 5;
   localparam int KIND_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_READ_ALL  = 3'd6
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // what the back end has to do with a classified item
   typedef enum logic [KIND_W-1:0] {
      KIND_REPORT = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   // width of one command word: kind, status, slot, count before, count after, value
   function automatic int cmd_width(input int depth);
      return KIND_W + STAT_W + $clog2(depth) + 2 * $clog2(depth + 1) + VAL_W;
   endfunction

endpackage

/* hdl/plst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/plst_cmdq.sv */
// Small command queue between the front and back ends of the list store.
// No dependencies.
module plst_cmdq #(
   parameter int WIDTH   = 64,
   parameter int ENTRIES = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(ENTRIES);
   localparam int NW = $clog2(ENTRIES + 1);

   logic [WIDTH-1:0] slot_ff [ENTRIES];
   logic [PW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [NW-1:0]    num_ff, num_in;
   logic             push, pop;

   assign push_ready = (num_ff != NW'(ENTRIES));
   assign pop_valid  = (num_ff != '0);
   assign pop_data   = slot_ff[rp_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      num_in = num_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(ENTRIES - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(ENTRIES - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         num_in = num_ff + 1'b1;
      end else if (pop && !push) begin
         num_in = num_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         num_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         num_ff <= num_in;
      end
   end

endmodule

/* hdl/plst_front.sv */
// Front end: accepts requests, tracks the list length and classifies each
// item into a command for the back end. Depends on plst_pkg.
module plst_front #(
   parameter int DEPTH = 16,
   localparam int AW    = $clog2(DEPTH),
   localparam int CW    = $clog2(DEPTH + 1),
   localparam int CMD_W = plst_pkg::cmd_width(DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [plst_pkg::OP_W-1:0]         req_op,
   input  logic signed [plst_pkg::VAL_W-1:0] req_value,
   input  logic [plst_pkg::POS_W-1:0]        req_position,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output logic [CMD_W-1:0]                  cmd_data
);

   localparam int PCW = ((CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W) + 1;

   typedef struct packed {
      plst_pkg::kind_type              kind;
      plst_pkg::status_type            status;
      logic [AW-1:0]                   idx;
      logic [CW-1:0]                   cb;
      logic [CW-1:0]                   ca;
      logic signed [plst_pkg::VAL_W-1:0] value;
   } cmd_type;

   cmd_type        cmd;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [PCW-1:0] pos_x, cnt_x;
   logic           empty, full, accept;

   assign pos_x  = PCW'(req_position);
   assign cnt_x  = PCW'(cnt_ff);
   assign empty  = (cnt_ff == '0);
   assign full   = (cnt_ff == CW'(DEPTH));

   always_comb begin
      cmd.kind   = plst_pkg::KIND_REPORT;
      cmd.status = plst_pkg::ST_OK;
      cmd.idx    = '0;
      cmd.cb     = cnt_ff;
      cmd.ca     = cnt_ff;
      cmd.value  = req_value;
      unique case (req_op)
         plst_pkg::OP_INS_FRONT, plst_pkg::OP_INS_BACK, plst_pkg::OP_INS_AT: begin
            priority if (empty) begin
               cmd.kind = plst_pkg::KIND_INSERT;
            end else if (full) begin
               cmd.status = plst_pkg::ST_FULL;
            end else if (req_op == plst_pkg::OP_INS_FRONT) begin
               cmd.kind = plst_pkg::KIND_INSERT;
            end else if (req_op == plst_pkg::OP_INS_BACK) begin
               cmd.kind = plst_pkg::KIND_INSERT;
               cmd.idx  = AW'(cnt_ff);
            end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
               cmd.status = plst_pkg::ST_BADPOS;
            end else begin
               cmd.kind = plst_pkg::KIND_INSERT;
               cmd.idx  = AW'(req_position - 1'b1);
            end
            if (cmd.kind == plst_pkg::KIND_INSERT) begin
               cmd.ca = cnt_ff + 1'b1;
            end
         end
         plst_pkg::OP_DEL_FRONT, plst_pkg::OP_DEL_BACK, plst_pkg::OP_DEL_AT: begin
            priority if (empty) begin
               cmd.status = plst_pkg::ST_EMPTY;
            end else if (req_op == plst_pkg::OP_DEL_FRONT) begin
               cmd.kind = plst_pkg::KIND_DELETE;
            end else if (req_op == plst_pkg::OP_DEL_BACK) begin
               cmd.kind = plst_pkg::KIND_DELETE;
               cmd.idx  = AW'(cnt_ff - 1'b1);
            end else if (pos_x == '0 || pos_x > cnt_x) begin
               cmd.status = plst_pkg::ST_BADPOS;
            end else begin
               cmd.kind = plst_pkg::KIND_DELETE;
               cmd.idx  = AW'(req_position - 1'b1);
            end
            if (cmd.kind == plst_pkg::KIND_DELETE) begin
               cmd.ca = cnt_ff - 1'b1;
            end
         end
         plst_pkg::OP_READ_ALL: begin
            if (empty) begin
               cmd.status = plst_pkg::ST_EMPTY;
            end else begin
               cmd.kind = plst_pkg::KIND_READ;
            end
         end
         default: begin
            cmd.kind = plst_pkg::KIND_REPORT;
         end
      endcase
   end

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign cmd_data  = cmd;
   assign accept    = req_valid && cmd_ready;
   assign cnt_in    = accept ? cmd.ca : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hdl/plst_back.sv */
// Back end: executes classified commands against the entry RAM, shifting
// entries for inserts and deletes and streaming reads. Depends on plst_pkg, plst_ram.
module plst_back #(
   parameter int DEPTH = 16,
   localparam int AW    = $clog2(DEPTH),
   localparam int CW    = $clog2(DEPTH + 1),
   localparam int CMD_W = plst_pkg::cmd_width(DEPTH)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   output logic                                  cmd_ready,
   input  logic [CMD_W-1:0]                      cmd_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [plst_pkg::VAL_W-1:0]     rsp_value_out,
   output logic [plst_pkg::STAT_W-1:0]           rsp_status,
   output logic [plst_pkg::CNT_OUT_W-1:0]        rsp_count_out,
   output logic                                  rsp_last
);

   typedef struct packed {
      plst_pkg::kind_type              kind;
      plst_pkg::status_type            status;
      logic [AW-1:0]                   idx;
      logic [CW-1:0]                   cb;
      logic [CW-1:0]                   ca;
      logic signed [plst_pkg::VAL_W-1:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_DRAIN,
      S_PUT,
      S_REPORT,
      S_RD_REQ,
      S_RD_OUT
   } state_type;

   cmd_type                            cmd;
   state_type                          state_ff, state_in;
   cmd_type                            c_ff, c_in;
   logic [AW-1:0]                      rd_ff, rd_in, wa_ff, wa_in;
   logic                               pend_ff, pend_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [plst_pkg::VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   plst_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [plst_pkg::CNT_OUT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               ram_we, ram_re;
   logic [AW-1:0]                      ram_wa, ram_ra;
   logic [plst_pkg::VAL_W-1:0]         ram_wd, ram_rdata;
   logic                               out_free, is_ins, shift_end, rd_last;

   assign cmd      = cmd_type'(cmd_data);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_ins   = (c_ff.kind == plst_pkg::KIND_INSERT);
   assign shift_end = is_ins ? (rd_ff == c_ff.idx) : (CW'(rd_ff) + 1'b1 == c_ff.cb);
   assign rd_last  = (CW'(rd_ff) + 1'b1 == c_ff.cb);

   plst_ram #(
      .WIDTH (plst_pkg::VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      c_in          = c_ff;
      rd_in         = rd_ff;
      wa_in         = wa_ff;
      pend_in       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      cmd_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_wa        = wa_ff;
      ram_wd        = ram_rdata;
      ram_re        = 1'b0;
      ram_ra        = rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               c_in = cmd;
               unique case (cmd.kind)
                  plst_pkg::KIND_REPORT: begin
                     state_in = S_REPORT;
                  end
                  plst_pkg::KIND_INSERT: begin
                     if (CW'(cmd.idx) == cmd.cb) begin
                        state_in = S_PUT;
                     end else begin
                        rd_in    = AW'(cmd.cb - 1'b1);
                        state_in = S_SHIFT;
                     end
                  end
                  plst_pkg::KIND_DELETE: begin
                     if (CW'(cmd.idx) + 1'b1 >= cmd.cb) begin
                        state_in = S_REPORT;
                     end else begin
                        rd_in    = cmd.idx + 1'b1;
                        state_in = S_SHIFT;
                     end
                  end
                  plst_pkg::KIND_READ: begin
                     rd_in    = '0;
                     state_in = S_RD_REQ;
                  end
                  default: begin
                     state_in = S_REPORT;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // read one slot, write the previous read one place on
            ram_re  = 1'b1;
            ram_we  = pend_ff;
            pend_in = 1'b1;
            wa_in   = is_ins ? rd_ff + 1'b1 : rd_ff - 1'b1;
            if (shift_end) begin
               state_in = S_DRAIN;
            end else begin
               rd_in = is_ins ? rd_ff - 1'b1 : rd_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            ram_we   = 1'b1;
            state_in = is_ins ? S_PUT : S_REPORT;
         end
         S_PUT: begin
            ram_we   = 1'b1;
            ram_wa   = c_ff.idx;
            ram_wd   = c_ff.value;
            state_in = S_REPORT;
         end
         S_REPORT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = c_ff.status;
               rsp_count_in  = plst_pkg::CNT_OUT_W'(c_ff.ca);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RD_REQ: begin
            ram_re   = 1'b1;
            state_in = S_RD_OUT;
         end
         S_RD_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ram_rdata;
               rsp_status_in = plst_pkg::ST_OK;
               rsp_count_in  = plst_pkg::CNT_OUT_W'(c_ff.ca);
               rsp_last_in   = rd_last;
               if (rd_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_in    = rd_ff + 1'b1;
                  state_in = S_RD_REQ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff      <= state_in;
      c_ff          <= c_in;
      rd_ff         <= rd_in;
      wa_ff         <= wa_in;
      pend_ff       <= pend_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count_out = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* hdl/positional_list_store.sv */
// Positional list store top level: front end, command queue, back end.
// Depends on plst_pkg, plst_front, plst_cmdq, plst_back (and plst_ram).
//
// An ordered list of up to DEPTH signed 32-bit values held packed in one RAM.
// The front end takes a request in any cycle the command queue has room,
// checks it against its own copy of the list length and passes a command on;
// the back end executes commands one at a time. An item that only reports
// passes through the accept and result states. An insert writes the new
// entry and, where entries lie behind the insertion point, first shifts them
// one place on through the single RAM read and write port; a delete that is
// not of the final entry shifts the entries behind it one place back. Read
// all reads the entries in order and gives each out as a result. A stalled
// result holds the back end until it is taken. Every non-read item gives one
// result with last set; read all of a non-empty list gives one result per
// entry. The RAM needs no clearing after reset.
module positional_list_store #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [plst_pkg::OP_W-1:0]         req_op,
   input  logic signed [plst_pkg::VAL_W-1:0] req_value,
   input  logic [plst_pkg::POS_W-1:0]        req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [plst_pkg::VAL_W-1:0] rsp_value_out,
   output logic [plst_pkg::STAT_W-1:0]       rsp_status,
   output logic [plst_pkg::CNT_OUT_W-1:0]    rsp_count_out,
   output logic                              rsp_last
);

   localparam int CMD_W   = plst_pkg::cmd_width(DEPTH);
   localparam int Q_SLOTS = 2;

   logic             f_valid, f_ready, b_valid, b_ready;
   logic [CMD_W-1:0] f_data, b_data;

   plst_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_value    (req_value),
      .req_position (req_position),
      .cmd_valid    (f_valid),
      .cmd_ready    (f_ready),
      .cmd_data     (f_data)
   );

   plst_cmdq #(
      .WIDTH   (CMD_W),
      .ENTRIES (Q_SLOTS)
   ) u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   plst_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (b_valid),
      .cmd_ready     (b_ready),
      .cmd_data      (b_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_count_out (rsp_count_out),
      .rsp_last      (rsp_last)
   );

endmodule
